// File: hw/rtl/hsv_to_rgb_converter_defines.svh
// Assertion macros for the HSV to RGB converter; clk and rst come from the enclosing scope.
`ifndef HSV_TO_RGB_CONVERTER_DEFINES_SVH
`define HSV_TO_RGB_CONVERTER_DEFINES_SVH

// Check cons in the same cycle as ante.
`define HSV2RGB_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check cons a fixed number of cycles after ante.
`define HSV2RGB_ASSERT_DELAY(lbl, ante, n, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##(n) (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/hsv2rgb_pkg.sv
// Shared types and constants for the HSV to RGB converter.
package hsv2rgb_pkg;

  localparam int OUT_BITS_DEF = 16;
  localparam int NUM_W = 32;

  localparam logic [15:0] SECTOR_SPAN = 16'd65280;

  typedef enum logic [2:0] {
    SEC_0 = 3'd0,
    SEC_1 = 3'd1,
    SEC_2 = 3'd2,
    SEC_3 = 3'd3,
    SEC_4 = 3'd4,
    SEC_5 = 3'd5
  } sector_t;

  typedef struct packed {
    sector_t     sector;
    logic [15:0] rem;
    logic [7:0]  sat;
    logic [7:0]  val;
  } hsv_sec_t;

endpackage

// File: hw/rtl/hsv2rgb_sector.sv
// Hue scaling and sector split: two pipeline stages.
module hsv2rgb_sector (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_vld,
  input  logic [15:0]           hue,
  input  logic [7:0]            sat,
  input  logic [7:0]            val,
  output logic                  out_vld,
  output hsv2rgb_pkg::hsv_sec_t sec
);

  localparam logic [18:0] SPAN19 = {3'd0, hsv2rgb_pkg::SECTOR_SPAN};
  localparam logic [18:0] BOUND1 = SPAN19 * 19'd1;
  localparam logic [18:0] BOUND2 = SPAN19 * 19'd2;
  localparam logic [18:0] BOUND3 = SPAN19 * 19'd3;
  localparam logic [18:0] BOUND4 = SPAN19 * 19'd4;
  localparam logic [18:0] BOUND5 = SPAN19 * 19'd5;
  localparam logic [18:0] BOUND6 = SPAN19 * 19'd6;

  logic        vld1;
  logic [18:0] h6;
  logic [7:0]  sat1;
  logic [7:0]  val1;

  hsv2rgb_pkg::sector_t sector_next;
  logic [18:0]          base_next;
  logic [18:0]          rem_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1    <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      vld1    <= in_vld;
      out_vld <= vld1;
    end
    h6         <= {1'b0, hue, 2'b00} + {2'b00, hue, 1'b0};
    sat1       <= sat;
    val1       <= val;
    sec.sector <= sector_next;
    sec.rem    <= rem_next[15:0];
    sec.sat    <= sat1;
    sec.val    <= val1;
  end

  // Hue at or above 255 folds back into the first sector.
  always_comb begin
    sector_next = hsv2rgb_pkg::SEC_0;
    base_next   = '0;
    priority if (h6 >= BOUND6) begin
      sector_next = hsv2rgb_pkg::SEC_0;
      base_next   = BOUND6;
    end else if (h6 >= BOUND5) begin
      sector_next = hsv2rgb_pkg::SEC_5;
      base_next   = BOUND5;
    end else if (h6 >= BOUND4) begin
      sector_next = hsv2rgb_pkg::SEC_4;
      base_next   = BOUND4;
    end else if (h6 >= BOUND3) begin
      sector_next = hsv2rgb_pkg::SEC_3;
      base_next   = BOUND3;
    end else if (h6 >= BOUND2) begin
      sector_next = hsv2rgb_pkg::SEC_2;
      base_next   = BOUND2;
    end else if (h6 >= BOUND1) begin
      sector_next = hsv2rgb_pkg::SEC_1;
      base_next   = BOUND1;
    end else begin
      sector_next = hsv2rgb_pkg::SEC_0;
      base_next   = '0;
    end
    rem_next = h6 - base_next;
  end

endmodule

// File: hw/rtl/hsv2rgb_chan.sv
// Channel numerators p, q, t, v and sector ordering: three pipeline stages.
module hsv2rgb_chan (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         in_vld,
  input  hsv2rgb_pkg::hsv_sec_t                        sec,
  output logic                                         out_vld,
  output logic [2:0][hsv2rgb_pkg::NUM_W-1:0]           num
);

  localparam logic [23:0] FULL_X = {8'd0, hsv2rgb_pkg::SECTOR_SPAN} * 24'd255;
  localparam logic [31:0] FULL_N = {8'd0, FULL_X};

  logic                 vld3;
  hsv2rgb_pkg::sector_t sector3;
  logic [7:0]           val3;
  logic [23:0]          xp;
  logic [23:0]          xq;
  logic [23:0]          xt;

  logic                 vld4;
  hsv2rgb_pkg::sector_t sector4;
  logic [31:0]          nv;
  logic [31:0]          np;
  logic [31:0]          nq;
  logic [31:0]          nt;

  logic [15:0]          rem_inv;
  logic [23:0]          sq_prod;
  logic [23:0]          st_prod;
  logic [7:0]           sat_inv;
  logic [2:0][31:0]     num_next;

  assign rem_inv = hsv2rgb_pkg::SECTOR_SPAN - sec.rem;
  assign sat_inv = 8'd255 - sec.sat;
  assign sq_prod = {16'd0, sec.sat} * {8'd0, sec.rem};
  assign st_prod = {16'd0, sec.sat} * {8'd0, rem_inv};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld3    <= 1'b0;
      vld4    <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      vld3    <= in_vld;
      vld4    <= vld3;
      out_vld <= vld4;
    end
    sector3 <= sec.sector;
    val3    <= sec.val;
    xp      <= {16'd0, sat_inv} * {8'd0, hsv2rgb_pkg::SECTOR_SPAN};
    xq      <= FULL_X - sq_prod;
    xt      <= FULL_X - st_prod;
    sector4 <= sector3;
    nv      <= {24'd0, val3} * FULL_N;
    np      <= {24'd0, val3} * {8'd0, xp};
    nq      <= {24'd0, val3} * {8'd0, xq};
    nt      <= {24'd0, val3} * {8'd0, xt};
    num     <= num_next;
  end

  // Index 0 is red, 1 green, 2 blue.
  always_comb begin
    unique case (sector4)
      hsv2rgb_pkg::SEC_1: num_next = {np, nv, nq};
      hsv2rgb_pkg::SEC_2: num_next = {nt, nv, np};
      hsv2rgb_pkg::SEC_3: num_next = {nv, nq, np};
      hsv2rgb_pkg::SEC_4: num_next = {nv, np, nt};
      hsv2rgb_pkg::SEC_5: num_next = {nq, np, nv};
      default:            num_next = {np, nt, nv};
    endcase
  end

endmodule

// File: hw/rtl/hsv2rgb_div.sv
// Division of the channel numerators by the fixed denominator through a reciprocal product.
module hsv2rgb_div #(
  parameter int OUT_BITS = hsv2rgb_pkg::OUT_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_vld,
  input  logic [2:0][hsv2rgb_pkg::NUM_W-1:0] num,
  output logic                               out_vld,
  output logic [2:0][OUT_BITS-1:0]           code
);

  // The denominator is 256 * 255^3: fold 256 and the rounding half into the
  // dividend, then divide by 255^3 with a reciprocal exact over the dividend range.
  localparam int CW = 24;
  localparam logic [CW-1:0] CUBE = 24'd16581375;
  localparam logic [CW-1:0] HALF = 24'd8290687;
  localparam int BW = hsv2rgb_pkg::NUM_W - 8 + OUT_BITS;
  localparam int KW = BW + CW;
  localparam int MW = BW + 1;
  localparam logic [KW:0] ONE_K = {1'b1, {KW{1'b0}}};
  localparam logic [KW:0] CUBE_K = {{(KW-CW+1){1'b0}}, CUBE};
  localparam logic [KW:0] RECIP_FULL = (ONE_K + CUBE_K - {{KW{1'b0}}, 1'b1}) / CUBE_K;
  localparam logic [MW-1:0] RECIP = RECIP_FULL[MW-1:0];

  localparam int SB = BW / 2;
  localparam int SM = MW / 2;
  localparam int S = SB + SM;
  localparam int PW = BW + MW;
  localparam int TOTW = PW - S;
  localparam int QL = KW - S;
  localparam int P11W = (BW - SB) + (MW - SM);
  localparam int P10W = (BW - SB) + SM;
  localparam int P01W = SB + (MW - SM);
  localparam int P00W = SB + SM;
  localparam logic [MW-SM-1:0] M_HI = RECIP[MW-1:SM];
  localparam logic [SM-1:0] M_LO = RECIP[SM-1:0];

  logic [3:0]               vld;
  logic [2:0][BW-1:0]       bq;
  logic [2:0][P11W-1:0]     p11;
  logic [2:0][P10W-1:0]     p10;
  logic [2:0][P01W-1:0]     p01;
  logic [2:0][P00W-1:0]     p00;
  logic [2:0][TOTW-1:0]     hi;
  logic [2:0][TOTW-1:0]     mid_hi;
  logic [2:0][OUT_BITS:0]   q;
  logic [2:0][BW-1:0]       b_next;
  logic [2:0][TOTW-1:0]     mid_next;
  logic [2:0][TOTW-1:0]     tot_next;
  logic [2:0][OUT_BITS-1:0] code_next;

  // Saturate 1.0 to all ones.
  always_comb begin
    logic [PW-1:0] mid_sum;
    mid_sum = '0;
    for (int k = 0; k < 3; k++) begin
      b_next[k]    = (BW'(num[k]) << (OUT_BITS - 8)) + BW'(HALF);
      mid_sum      = (PW'(p10[k]) << SB) + (PW'(p01[k]) << SM) + PW'(p00[k]);
      mid_next[k]  = mid_sum[PW-1:S];
      tot_next[k]  = hi[k] + mid_hi[k];
      code_next[k] = q[k][OUT_BITS] ? '1 : q[k][OUT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      out_vld <= 1'b0;
    end else begin
      vld     <= {vld[2:0], in_vld};
      out_vld <= vld[3];
    end
    bq <= b_next;
    for (int k = 0; k < 3; k++) begin
      p11[k] <= P11W'(bq[k][BW-1:SB]) * P11W'(M_HI);
      p10[k] <= P10W'(bq[k][BW-1:SB]) * P10W'(M_LO);
      p01[k] <= P01W'(bq[k][SB-1:0]) * P01W'(M_HI);
      p00[k] <= P00W'(bq[k][SB-1:0]) * P00W'(M_LO);
      hi[k]  <= p11[k];
      q[k]   <= tot_next[k][TOTW-1:QL];
    end
    mid_hi <= mid_next;
    code   <= code_next;
  end

endmodule

// File: hw/rtl/hsv_to_rgb_converter.sv
// Top level of the HSV to RGB converter pipeline.
//
// Request channel: hue (unsigned 8.8, wraps at 255), saturation and brightness
// (0..255, 255 is full scale). A request is taken at a rising edge where start
// is high and busy is low. busy is high only while rst is high, so outside of
// reset a request can be taken on every clock.
// Result channel: red, green and blue as unsigned Q0.OUT_BITS codes, 1.0
// saturating to all ones, shown for exactly one cycle with done high.
// Throughput: one request per clock; ten register stages, two for the sector
// split, three for the channel numerators and five for the reciprocal divide.
// Reset: synchronous rst clears every valid bit; requests in flight are dropped.
// The receiver cannot stall: results leave the pipeline unconditionally.
module hsv_to_rgb_converter #(
  parameter int OUT_BITS = hsv2rgb_pkg::OUT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [15:0]         hue,
  input  logic [7:0]          saturation,
  input  logic [7:0]          brightness,
  output logic                done,
  output logic [OUT_BITS-1:0] red,
  output logic [OUT_BITS-1:0] green,
  output logic [OUT_BITS-1:0] blue
);

  logic                               req_vld;
  logic                               sec_vld;
  hsv2rgb_pkg::hsv_sec_t              sec;
  logic                               num_vld;
  logic [2:0][hsv2rgb_pkg::NUM_W-1:0] num;
  logic [2:0][OUT_BITS-1:0]           code;

  assign busy    = rst;
  assign req_vld = start & ~busy;

  hsv2rgb_sector u_sector (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (req_vld),
    .hue     (hue),
    .sat     (saturation),
    .val     (brightness),
    .out_vld (sec_vld),
    .sec     (sec)
  );

  hsv2rgb_chan u_chan (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (sec_vld),
    .sec     (sec),
    .out_vld (num_vld),
    .num     (num)
  );

  hsv2rgb_div #(
    .OUT_BITS (OUT_BITS)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (num_vld),
    .num     (num),
    .out_vld (done),
    .code    (code)
  );

  assign red   = code[0];
  assign green = code[1];
  assign blue  = code[2];

endmodule

// File: hw/rtl/hsv2rgb_checker.sv
// Port-level assertions for the HSV to RGB converter and their bind.
`include "hsv_to_rgb_converter_defines.svh"

module hsv2rgb_checker #(
  parameter int OUT_BITS = hsv2rgb_pkg::OUT_BITS_DEF
) (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input logic [15:0]         hue,
  input logic [7:0]          saturation,
  input logic [7:0]          brightness,
  input logic                done,
  input logic [OUT_BITS-1:0] red,
  input logic [OUT_BITS-1:0] green,
  input logic [OUT_BITS-1:0] blue
);

  localparam int LAT = 10;
  localparam logic [OUT_BITS-1:0] CODE_MAX = '1;

  `HSV2RGB_ASSERT_DELAY(a_latency, start && !busy, LAT, done, "request without matching result")
  `HSV2RGB_ASSERT_IMPL(a_no_spurious, done, $past(start && !busy, LAT), "result without request")
  `HSV2RGB_ASSERT_DELAY(a_black, start && !busy && brightness == 8'd0, LAT, red == '0 && green == '0 && blue == '0, "zero brightness not black")
  `HSV2RGB_ASSERT_DELAY(a_pure_red, start && !busy && hue == 16'd0 && saturation == 8'd255 && brightness == 8'd255, LAT, red == CODE_MAX && green == '0 && blue == '0, "pure red hue wrong")

endmodule

bind hsv_to_rgb_converter hsv2rgb_checker #(.OUT_BITS(OUT_BITS)) u_hsv2rgb_checker (.*);
